### rtl/ertbl_pkg.sv
// ----------------------------------------------------------------------------
// ertbl_pkg
// Shared constants, status codes and controller/datapath interface types
// for the extended residue table engine.
// ----------------------------------------------------------------------------
package ertbl_pkg;

	localparam int ERT_MAX_WEIGHTS = 8;
	localparam int ERT_TABLE_DEPTH = 4096;
	localparam int ERT_VALUE_BITS  = 40;

	localparam int MASS_W   = 40;
	localparam int LEVEL_W  = 3;
	localparam int STATUS_W = 2;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 48;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_FIRST = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd3;

	typedef struct packed {
		logic                capture;
		logic                list_clear;
		logic                load_store;
		logic                set_ready;
		logic                div_start;
		logic                div_weight;
		logic                init_first;
		logic                init_wr;
		logic                build_first;
		logic                gcd_init;
		logic                gcd_step;
		logic                p_first;
		logic                p_next;
		logic                j_next;
		logic                scan_first;
		logic                scan_rd;
		logic                scan_cmp;
		logic                fill_first;
		logic                fill_wr;
		logic                walk_first;
		logic                walk_rd;
		logic                walk_wr;
		logic                q_rd;
		logic                res_write;
		logic                res_query;
		logic [STATUS_W-1:0] res_status;
	} dp_cmd_t;

	typedef struct packed {
		logic func;
		logic last;
		logic first_bad;
		logic full;
		logic query_ok;
		logic div_done;
		logic init_last;
		logic one_weight;
		logic gcd_done;
		logic stride_last;
		logic n_inf;
		logic walk_last;
		logic p_last;
		logic j_last;
		logic out_busy;
	} dp_stat_t;

endpackage

### rtl/ertbl_mod.sv
// ----------------------------------------------------------------------------
// ertbl_mod
// Restoring remainder unit: dividend mod divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ertbl_mod import ertbl_pkg::*; #(
	parameter int VALUE_BITS = ERT_VALUE_BITS,
	parameter int AW         = 13
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [AW-1:0]         divisor,
	output logic                  done,
	output logic [AW-1:0]         rem
);

	localparam int CW = $clog2(VALUE_BITS + 1);

	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [VALUE_BITS-1:0] sh_q;
	logic [AW-1:0]         rem_q;
	logic [AW:0]           trial;

	assign trial = {rem_q, sh_q[VALUE_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q <= {sh_q[VALUE_BITS-2:0], 1'b0};
			if (trial >= {1'b0, divisor})
				rem_q <= AW'(trial - {1'b0, divisor});
			else
				rem_q <= AW'(trial);
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

### rtl/ertbl_dp.sv
// ----------------------------------------------------------------------------
// ertbl_dp
// Datapath: weight list, residue table memory, build counters, remainder
// unit and result register.
// ----------------------------------------------------------------------------
module ertbl_dp import ertbl_pkg::*; #(
	parameter int MAX_WEIGHTS = ERT_MAX_WEIGHTS,
	parameter int TABLE_DEPTH = ERT_TABLE_DEPTH,
	parameter int VALUE_BITS  = ERT_VALUE_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic                in_func,
	input  logic [MASS_W-1:0]   in_mass,
	input  logic [LEVEL_W-1:0]  in_level,
	input  logic                in_last,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_decomposable,
	output logic [MASS_W-1:0]   out_least_mass,
	output logic [STATUS_W-1:0] out_status
);

	localparam int RB        = $clog2(TABLE_DEPTH);
	localparam int AW        = RB + 1;
	localparam int JB        = $clog2(MAX_WEIGHTS);
	localparam int CB        = $clog2(MAX_WEIGHTS + 1);
	localparam int MEM_DEPTH = 2 ** (JB + RB);
	localparam int XW        = VALUE_BITS + 18;
	localparam logic [VALUE_BITS-1:0] VMASK = '1;

	logic                  func_q, last_q;
	logic [VALUE_BITS-1:0] mass_q;
	logic [LEVEL_W-1:0]    level_q;
	logic [VALUE_BITS-1:0] weight_q [MAX_WEIGHTS];
	logic [AW-1:0]         a_q;
	logic [CB-1:0]         count_q;
	logic                  ready_q;
	logic [CB-1:0]         j_q;
	logic [AW-1:0]         i_q, p_q, x_q, y_q, step_q, at_q, r_q;
	logic [VALUE_BITS-1:0] n_q;
	logic [VALUE_BITS-1:0] rdata_q;
	logic [VALUE_BITS-1:0] mem [MEM_DEPTH];

	logic                  out_valid_q;
	logic                  out_dec_q;
	logic [MASS_W-1:0]     out_mass_q;
	logic [STATUS_W-1:0]   out_status_q;

	logic [CB-1:0]         eff_count;
	logic [VALUE_BITS-1:0] cur_w;
	logic [AW:0]           i_next, r_sum;
	logic [AW-1:0]         r_next;
	logic [VALUE_BITS-1:0] n_sat, n_min;
	logic                  div_done;
	logic [AW-1:0]         div_rem;
	logic [JB-1:0]         j_idx, jm1_idx;
	logic [JB+RB-1:0]      raddr, waddr;
	logic [VALUE_BITS-1:0] wdata;
	logic                  rd_en, wr_en;

	assign eff_count = ready_q ? '0 : count_q;
	assign cur_w     = weight_q[JB'(j_q)];
	assign i_next    = {1'b0, i_q} + {1'b0, x_q};
	assign r_sum     = {1'b0, r_q} + {1'b0, step_q};
	assign r_next    = (r_sum >= {1'b0, a_q}) ? AW'(r_sum - {1'b0, a_q}) : AW'(r_sum);
	assign n_sat     = (n_q >= VMASK - cur_w) ? VMASK : n_q + cur_w;
	assign n_min     = (rdata_q < n_q) ? rdata_q : n_q;
	assign j_idx     = JB'(j_q);
	assign jm1_idx   = JB'(j_q - 1'b1);

	ertbl_mod #(
		.VALUE_BITS(VALUE_BITS),
		.AW        (AW)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(cmd.div_weight ? cur_w : mass_q),
		.divisor (a_q),
		.done    (div_done),
		.rem     (div_rem)
	);

	always_comb begin
		stat.func        = func_q;
		stat.last        = last_q;
		stat.first_bad   = (eff_count == '0) && ((mass_q == '0) ||
			({18'd0, mass_q} > XW'(TABLE_DEPTH)));
		stat.full        = (eff_count >= CB'(MAX_WEIGHTS));
		stat.query_ok    = ready_q && ({{CB{1'b0}}, level_q} < {{LEVEL_W{1'b0}}, count_q});
		stat.div_done    = div_done;
		stat.init_last   = (i_q == a_q - 1'b1);
		stat.one_weight  = (count_q == CB'(1));
		stat.gcd_done    = (y_q == '0);
		stat.stride_last = (i_next >= {1'b0, a_q});
		stat.n_inf       = (n_q == VMASK);
		stat.walk_last   = (r_q == at_q);
		stat.p_last      = (p_q + 1'b1 == x_q);
		stat.j_last      = (j_q + 1'b1 == count_q);
		stat.out_busy    = out_valid_q;
	end

	// read port: query, scan of the previous level, or next walk residue
	always_comb begin
		rd_en = cmd.q_rd | cmd.scan_rd | cmd.walk_rd;
		if (cmd.q_rd)
			raddr = {JB'(level_q), RB'(div_rem)};
		else if (cmd.walk_rd)
			raddr = {jm1_idx, RB'(r_next)};
		else
			raddr = {jm1_idx, RB'(i_q)};
	end

	always_comb begin
		wr_en = cmd.init_wr | cmd.fill_wr | cmd.walk_wr;
		if (cmd.init_wr) begin
			waddr = {JB'(0), RB'(i_q)};
			wdata = (i_q == '0) ? '0 : VMASK;
		end else if (cmd.fill_wr) begin
			waddr = {j_idx, RB'(i_q)};
			wdata = VMASK;
		end else begin
			waddr = {j_idx, RB'(r_q)};
			wdata = n_min;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[waddr] <= wdata;
		if (rd_en)
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= in_func;
			mass_q  <= VALUE_BITS'(in_mass);
			level_q <= in_level;
			last_q  <= in_last;
		end
		if (cmd.load_store) begin
			weight_q[JB'(eff_count)] <= mass_q;
			if (eff_count == '0)
				a_q <= AW'(mass_q);
		end
		if (cmd.init_first)
			i_q <= '0;
		if (cmd.init_wr)
			i_q <= i_q + 1'b1;
		if (cmd.gcd_init) begin
			x_q    <= a_q;
			y_q    <= div_rem;
			step_q <= div_rem;
		end
		if (cmd.gcd_step) begin
			if (x_q >= y_q) begin
				x_q <= x_q - y_q;
			end else begin
				x_q <= y_q;
				y_q <= x_q;
			end
		end
		if (cmd.p_first)
			p_q <= '0;
		if (cmd.p_next)
			p_q <= p_q + 1'b1;
		if (cmd.scan_first) begin
			i_q  <= p_q;
			n_q  <= VMASK;
			at_q <= p_q;
		end
		if (cmd.scan_cmp) begin
			if (rdata_q < n_q) begin
				n_q  <= rdata_q;
				at_q <= i_q;
			end
			i_q <= AW'(i_next);
		end
		if (cmd.fill_first)
			i_q <= p_q;
		if (cmd.fill_wr)
			i_q <= AW'(i_next);
		if (cmd.walk_first)
			r_q <= at_q;
		if (cmd.walk_rd) begin
			n_q <= n_sat;
			r_q <= r_next;
		end
		if (cmd.walk_wr)
			n_q <= n_min;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ready_q     <= 1'b0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.list_clear) begin
				count_q <= '0;
				ready_q <= 1'b0;
			end
			if (cmd.load_store) begin
				count_q <= eff_count + 1'b1;
				ready_q <= 1'b0;
			end
			if (cmd.set_ready)
				ready_q <= 1'b1;
			if (cmd.build_first)
				j_q <= CB'(1);
			if (cmd.j_next)
				j_q <= j_q + 1'b1;
			if (cmd.res_write)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_write) begin
			out_status_q <= cmd.res_status;
			if (cmd.res_query) begin
				out_mass_q <= MASS_W'(rdata_q);
				out_dec_q  <= (rdata_q != VMASK) && (rdata_q <= mass_q);
			end else begin
				out_mass_q <= '0;
				out_dec_q  <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign out_decomposable = out_dec_q;
	assign out_least_mass   = out_mass_q;
	assign out_status       = out_status_q;

endmodule

### rtl/ertbl_ctrl.sv
// ----------------------------------------------------------------------------
// ertbl_ctrl
// Controller: decodes each word, sequences the table build and the query
// lookup, and hands the result to the output register.
// ----------------------------------------------------------------------------
module ertbl_ctrl import ertbl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [15:0] {
		S_IDLE     = 16'h0001,
		S_DECODE   = 16'h0002,
		S_QDIV     = 16'h0004,
		S_INIT     = 16'h0008,
		S_WSTART   = 16'h0010,
		S_WDIV     = 16'h0020,
		S_GCD      = 16'h0040,
		S_PSTART   = 16'h0080,
		S_SCAN_RD  = 16'h0100,
		S_SCAN_CMP = 16'h0200,
		S_SCAN_END = 16'h0400,
		S_FILL     = 16'h0800,
		S_WALK_RD  = 16'h1000,
		S_WALK_WR  = 16'h2000,
		S_PNEXT    = 16'h4000,
		S_RESULT   = 16'h8000
	} state_t;

	state_t              state_q, state_d;
	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic                res_query_q, res_query_d;

	always_comb begin
		state_d      = state_q;
		res_status_d = res_status_q;
		res_query_d  = res_query_q;
		cmd          = '0;
		in_ready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				res_query_d  = 1'b0;
				res_status_d = ST_OK;
				if (!stat.func) begin
					if (stat.first_bad) begin
						cmd.list_clear = 1'b1;
						res_status_d   = ST_BAD_FIRST;
						state_d        = S_RESULT;
					end else if (stat.full) begin
						cmd.list_clear = 1'b1;
						res_status_d   = ST_OVERFLOW;
						state_d        = S_RESULT;
					end else begin
						cmd.load_store = 1'b1;
						if (stat.last) begin
							cmd.init_first = 1'b1;
							state_d        = S_INIT;
						end else begin
							state_d = S_RESULT;
						end
					end
				end else if (!stat.query_ok) begin
					res_status_d = ST_NOT_READY;
					state_d      = S_RESULT;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_QDIV;
				end
			end
			S_QDIV: begin
				if (stat.div_done) begin
					cmd.q_rd    = 1'b1;
					res_query_d = 1'b1;
					state_d     = S_RESULT;
				end
			end
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (stat.init_last) begin
					if (stat.one_weight) begin
						cmd.set_ready = 1'b1;
						state_d       = S_RESULT;
					end else begin
						cmd.build_first = 1'b1;
						state_d         = S_WSTART;
					end
				end
			end
			S_WSTART: begin
				cmd.div_start  = 1'b1;
				cmd.div_weight = 1'b1;
				state_d        = S_WDIV;
			end
			S_WDIV: begin
				if (stat.div_done) begin
					cmd.gcd_init = 1'b1;
					state_d      = S_GCD;
				end
			end
			S_GCD: begin
				if (stat.gcd_done) begin
					cmd.p_first = 1'b1;
					state_d     = S_PSTART;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_PSTART: begin
				cmd.scan_first = 1'b1;
				state_d        = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				cmd.scan_cmp = 1'b1;
				state_d      = stat.stride_last ? S_SCAN_END : S_SCAN_RD;
			end
			S_SCAN_END: begin
				if (stat.n_inf) begin
					cmd.fill_first = 1'b1;
					state_d        = S_FILL;
				end else begin
					cmd.walk_first = 1'b1;
					state_d        = S_WALK_RD;
				end
			end
			S_FILL: begin
				cmd.fill_wr = 1'b1;
				if (stat.stride_last)
					state_d = S_PNEXT;
			end
			S_WALK_RD: begin
				cmd.walk_rd = 1'b1;
				state_d     = S_WALK_WR;
			end
			S_WALK_WR: begin
				// back at the minimum's residue closes the cycle
				cmd.walk_wr = 1'b1;
				state_d     = stat.walk_last ? S_PNEXT : S_WALK_RD;
			end
			S_PNEXT: begin
				if (!stat.p_last) begin
					cmd.p_next = 1'b1;
					state_d    = S_PSTART;
				end else if (!stat.j_last) begin
					cmd.j_next = 1'b1;
					state_d    = S_WSTART;
				end else begin
					cmd.set_ready = 1'b1;
					state_d       = S_RESULT;
				end
			end
			S_RESULT: begin
				cmd.res_status = res_status_q;
				cmd.res_query  = res_query_q;
				if (!stat.out_busy) begin
					cmd.res_write = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			res_status_q <= ST_OK;
			res_query_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			res_status_q <= res_status_d;
			res_query_q  <= res_query_d;
		end
	end

endmodule

### rtl/extended_residue_table_engine_unit.sv
// ----------------------------------------------------------------------------
// extended_residue_table_engine_unit
// Loads a weight list, builds the round-robin extended residue table and
// answers decomposability queries against it.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  s_*      in   tuser=func, tdata=mass[39:0] level[42:40], tlast=last
//  m_*      out  tdata=decomposable[0] least_mass[40:1] status[42:41]
//
// A query divides the mass by the first weight in the one-bit-a-cycle
// remainder unit, then reads the table. A final load adds the build:
// level 0 is initialised, then each further weight takes its residue
// modulo the first weight, runs the gcd loop, and scans and walks the
// table. The table memory has one read and one write port.
// Reset clears the weight count and the ready flag; the table is not cleared.
// A result held in the output register stalls only the next result.
module extended_residue_table_engine_unit import ertbl_pkg::*; #(
	parameter int MAX_WEIGHTS = ERT_MAX_WEIGHTS,
	parameter int TABLE_DEPTH = ERT_TABLE_DEPTH,
	parameter int VALUE_BITS  = ERT_VALUE_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // mass, level, zero pad
	input  logic                s_tuser,   // func
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata    // decomposable, least_mass, status, zero pad
);

	dp_cmd_t             cmd;
	dp_stat_t            stat;
	logic                dec;
	logic [MASS_W-1:0]   least;
	logic [STATUS_W-1:0] status;

	ertbl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.cmd     (cmd),
		.stat    (stat)
	);

	ertbl_dp #(
		.MAX_WEIGHTS(MAX_WEIGHTS),
		.TABLE_DEPTH(TABLE_DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_func         (s_tuser),
		.in_mass         (s_tdata[MASS_W-1:0]),
		.in_level        (s_tdata[MASS_W+LEVEL_W-1:MASS_W]),
		.in_last         (s_tlast),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_decomposable(dec),
		.out_least_mass  (least),
		.out_status      (status)
	);

	assign m_tdata = M_DATA_W'({status, least, dec});

endmodule
